// ===== design/ksof_pkg.sv =====
package ksof_pkg;

  // Field widths fixed by the interface.
  localparam int VALUE_W = 17;
  localparam int THR_W = 8;
  localparam int K2_W = 2 * THR_W;
  localparam int IDX_W = 6;

  // Threshold of 3.0 sigma, in units of 1/16 sigma.
  localparam logic [THR_W-1:0] THR_RESET = 8'd48;

  // At most this many results are produced for one run.
  localparam int RESULT_CAP = 64;

  localparam int MAX_FRAMES_DEFAULT = 64;

  // Depths of the run queue and of the result queue.
  localparam int RUN_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  typedef struct packed {
    logic [IDX_W-1:0] frame_index;
    logic             entry_valid;
    logic             list_end;
    logic             overflow;
  } result_t;

endpackage

// ===== design/k_sigma_outlier_frame_flagger_top.sv =====
// Flags outlier frames of a run: each frame median is stored and summed, and
// the frame marked last closes the run and starts an exact integer test of
// every stored frame against mean +/- k*sigma (k = thresh_k/16). A frame
// is first captured in a register, then written to the store and put
// through the 17x17 square-and-accumulate; the input reports full in
// between, so no new frame is taken before the last one is stored. After
// the last frame the input reports full until the run is evaluated. The
// evaluation runs on one bit-serial multiplier: three products for the
// threshold term, then one square per stored frame. Flagged indices come
// out oldest first through a four-entry result queue, the last one marked
// by list_end; a run without outliers gives one result with entry_valid
// low. Frames past MAX_FRAMES are dropped and set overflow.
module k_sigma_outlier_frame_flagger_top #(
  parameter int MAX_FRAMES = ksof_pkg::MAX_FRAMES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ksof_pkg::VALUE_W-1:0] median_value,
  input  logic                         last_frame,
  output logic                         empty,
  input  logic                         pop,
  output logic [ksof_pkg::IDX_W-1:0]   frame_index,
  output logic                         entry_valid,
  output logic                         list_end,
  output logic                         overflow,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ksof_pkg::THR_W-1:0]   cfg_data
);
  import ksof_pkg::*;

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int SW = VALUE_W + CW;
  localparam int QW = 2 * VALUE_W + CW;
  localparam int DW = CW + SW + QW + 1;
  localparam int RW = $bits(result_t);

  logic [THR_W-1:0]   thresh_k;
  logic               hold;
  logic               desc_push;
  logic [CW-1:0]      f_n;
  logic [SW-1:0]      f_sum;
  logic [QW-1:0]      f_sq;
  logic               f_drop;
  logic               desc_full;
  logic               desc_empty;
  logic               desc_pop;
  logic [DW-1:0]      desc_q;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               res_push;
  result_t            res;
  logic               res_full;
  logic [RW-1:0]      res_q;
  result_t            res_out;
  logic               back_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_k <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh_k <= cfg_data;
    end
  end

  ksof_front #(
    .MAX_FRAMES(MAX_FRAMES),
    .CW(CW),
    .AW(AW),
    .SW(SW),
    .QW(QW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .median_value(median_value),
    .last_frame  (last_frame),
    .full        (full),
    .hold        (hold),
    .desc_push   (desc_push),
    .desc_n      (f_n),
    .desc_sum    (f_sum),
    .desc_sq     (f_sq),
    .desc_drop   (f_drop),
    .desc_full   (desc_full),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  ksof_fifo #(
    .WIDTH(DW),
    .DEPTH(RUN_Q_DEPTH)
  ) u_run_q (
    .clk  (clk),
    .rst  (rst),
    .push (desc_push),
    .din  ({f_n, f_sum, f_sq, f_drop}),
    .full (desc_full),
    .pop  (desc_pop),
    .dout (desc_q),
    .empty(desc_empty)
  );

  // The store belongs to the run under evaluation until the back end is done.
  assign hold = !desc_empty || back_busy;

  ksof_back #(
    .MAX_FRAMES(MAX_FRAMES),
    .CW(CW),
    .AW(AW),
    .SW(SW),
    .QW(QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .thresh_k  (thresh_k),
    .desc_empty(desc_empty),
    .desc_pop  (desc_pop),
    .desc_n    (desc_q[DW-1 -: CW]),
    .desc_sum  (desc_q[SW+QW : QW+1]),
    .desc_sq   (desc_q[QW : 1]),
    .desc_drop (desc_q[0]),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (back_busy),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  ksof_fifo #(
    .WIDTH(RW),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (res_q),
    .empty(empty)
  );

  assign res_out     = res_q;
  assign frame_index = res_out.frame_index;
  assign entry_valid = res_out.entry_valid;
  assign list_end    = res_out.list_end;
  assign overflow    = res_out.overflow;

endmodule

// ===== design/ksof_fifo.sv =====
module ksof_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // The fill count must never exceed the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== design/ksof_mul.sv =====
module ksof_mul #(
  parameter int A_W = 8,
  parameter int B_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);
  localparam int P_W = A_W + B_W;
  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [P_W-1:0]   ma;
  logic [B_W-1:0]   mb;
  logic [CNT_W-1:0] cnt;
  logic             load;

  assign load = start && !busy;

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ma   <= P_W'(a);
      mb   <= b;
      prod <= '0;
    end else if (busy) begin
      if (mb[0]) begin
        prod <= prod + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

endmodule

// ===== design/ksof_front.sv =====
module ksof_front #(
  parameter int MAX_FRAMES = ksof_pkg::MAX_FRAMES_DEFAULT,
  parameter int CW = $clog2(MAX_FRAMES + 1),
  parameter int AW = $clog2(MAX_FRAMES),
  parameter int SW = ksof_pkg::VALUE_W + CW,
  parameter int QW = 2 * ksof_pkg::VALUE_W + CW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [ksof_pkg::VALUE_W-1:0] median_value,
  input  logic                        last_frame,
  output logic                        full,
  input  logic                        hold,
  output logic                        desc_push,
  output logic [CW-1:0]               desc_n,
  output logic [SW-1:0]               desc_sum,
  output logic [QW-1:0]               desc_sq,
  output logic                        desc_drop,
  input  logic                        desc_full,
  input  logic [AW-1:0]               rd_addr,
  output logic [ksof_pkg::VALUE_W-1:0] rd_data
);
  import ksof_pkg::*;

  localparam int SQ_W = 2 * VALUE_W;

  logic [VALUE_W-1:0] store [MAX_FRAMES];
  logic [VALUE_W-1:0] pv;
  logic               plast;
  logic               pvalid;
  logic [CW-1:0]      count;
  logic [SW-1:0]      sum;
  logic [QW-1:0]      sq;
  logic               drop;
  logic               has_room;
  logic               stored;
  logic [SQ_W-1:0]    sq_term;
  logic [CW-1:0]      count_next;
  logic [SW-1:0]      sum_next;
  logic [QW-1:0]      sq_next;
  logic               drop_next;

  assign full     = pvalid || hold;
  assign has_room = (count < CW'(MAX_FRAMES));
  assign stored   = pvalid && has_room;
  assign sq_term  = SQ_W'(pv) * SQ_W'(pv);

  always_comb begin
    count_next = count;
    sum_next   = sum;
    sq_next    = sq;
    drop_next  = drop;
    if (stored) begin
      count_next = count + 1'b1;
      sum_next   = sum + SW'(pv);
      sq_next    = sq + QW'(sq_term);
    end else if (pvalid) begin
      drop_next = 1'b1;
    end
  end

  // The last frame hands the finished totals of the run to the back end.
  assign desc_push = pvalid && plast;
  assign desc_n    = count_next;
  assign desc_sum  = sum_next;
  assign desc_sq   = sq_next;
  assign desc_drop = drop_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      count  <= '0;
      sum    <= '0;
      sq     <= '0;
      drop   <= 1'b0;
    end else begin
      pvalid <= push && !full;
      if (pvalid) begin
        if (plast) begin
          count <= '0;
          sum   <= '0;
          sq    <= '0;
          drop  <= 1'b0;
        end else begin
          count <= count_next;
          sum   <= sum_next;
          sq    <= sq_next;
          drop  <= drop_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      pv    <= median_value;
      plast <= last_frame;
    end
    if (stored) begin
      store[count[AW-1:0]] <= pv;
    end
    rd_data <= store[rd_addr];
  end

  // Input is held off while a run waits, so the run queue always has room.
  a_desc_room: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> !desc_full)
    else $error("run request pushed into a full queue");

endmodule

// ===== design/ksof_back.sv =====
module ksof_back #(
  parameter int MAX_FRAMES = ksof_pkg::MAX_FRAMES_DEFAULT,
  parameter int CW = $clog2(MAX_FRAMES + 1),
  parameter int AW = $clog2(MAX_FRAMES),
  parameter int SW = ksof_pkg::VALUE_W + CW,
  parameter int QW = 2 * ksof_pkg::VALUE_W + CW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ksof_pkg::THR_W-1:0]   thresh_k,
  input  logic                        desc_empty,
  output logic                        desc_pop,
  input  logic [CW-1:0]               desc_n,
  input  logic [SW-1:0]               desc_sum,
  input  logic [QW-1:0]               desc_sq,
  input  logic                        desc_drop,
  output logic [AW-1:0]               rd_addr,
  input  logic [ksof_pkg::VALUE_W-1:0] rd_data,
  output logic                        busy,
  output logic                        res_push,
  output ksof_pkg::result_t           res,
  input  logic                        res_full
);
  import ksof_pkg::*;

  localparam int MA = QW + CW;
  localparam int MB = SW;
  localparam int PW = MA + MB;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NQ    = 4'd1;
  localparam logic [3:0] S_NQ_W  = 4'd2;
  localparam logic [3:0] S_SS_W  = 4'd3;
  localparam logic [3:0] S_RHS_W = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_NV    = 4'd6;
  localparam logic [3:0] S_D     = 4'd7;
  localparam logic [3:0] S_D2_W  = 4'd8;
  localparam logic [3:0] S_EVAL  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CW-1:0]    n;
  logic [SW-1:0]    sum;
  logic [QW-1:0]    sq;
  logic             drop;
  logic [K2_W-1:0]  k2;
  logic [MA-1:0]    nq;
  logic [PW-1:0]    rhs;
  logic [AW-1:0]    idx;
  logic [SW-1:0]    nv;
  logic             flag;
  logic             held_valid;
  logic [IDX_W-1:0] held_idx;
  logic [IDX_W-1:0] found;

  logic             mul_start;
  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic             mul_busy;
  logic             mul_done;
  logic [PW-1:0]    prod;

  logic [MA-1:0]    var_w;
  logic [SW-1:0]    d_w;
  logic             last_idx;
  logic             cap;
  logic             advance;

  ksof_mul #(
    .A_W(MA),
    .B_W(MB)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .busy (mul_busy),
    .done (mul_done),
    .prod (prod)
  );

  assign busy    = (state != S_IDLE);
  assign rd_addr = idx;

  // n*Q - S^2 is never negative, so the difference fits without a sign.
  assign var_w    = nq - prod[MA-1:0];
  assign d_w      = (nv >= sum) ? nv - sum : sum - nv;
  assign last_idx = (CW'(idx) == n - CW'(1));
  assign cap      = flag && (found == IDX_W'(RESULT_CAP - 1));
  assign advance  = !flag || !held_valid || !res_full;

  always_comb begin
    state_next = state;
    desc_pop   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    res_push   = 1'b0;
    res        = '0;
    res.overflow = drop;
    case (state)
      S_IDLE: begin
        if (!desc_empty) begin
          desc_pop   = 1'b1;
          state_next = S_NQ;
        end
      end
      S_NQ: begin
        mul_start  = 1'b1;
        mul_a      = MA'(sq);
        mul_b      = MB'(n);
        state_next = S_NQ_W;
      end
      S_NQ_W: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MA'(sum);
          mul_b      = sum;
          state_next = S_SS_W;
        end
      end
      S_SS_W: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = var_w;
          mul_b      = MB'(k2);
          state_next = S_RHS_W;
        end
      end
      S_RHS_W: begin
        if (mul_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_NV;
      end
      S_NV: begin
        state_next = S_D;
      end
      S_D: begin
        mul_start  = 1'b1;
        mul_a      = MA'(d_w);
        mul_b      = d_w;
        state_next = S_D2_W;
      end
      S_D2_W: begin
        if (mul_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        // A flagged frame is held back one step, so that the last one can
        // carry the end-of-list mark.
        if (advance) begin
          res_push        = flag && held_valid;
          res.frame_index = held_idx;
          res.entry_valid = 1'b1;
          state_next      = (last_idx || cap) ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (!res_full) begin
          res_push        = 1'b1;
          res.frame_index = held_valid ? held_idx : '0;
          res.entry_valid = held_valid;
          res.list_end    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_valid <= 1'b0;
      found      <= '0;
    end else begin
      state <= state_next;
      if (state == S_EVAL && advance && flag) begin
        held_valid <= 1'b1;
        found      <= found + 1'b1;
      end
      if (state == S_FIN && !res_full) begin
        held_valid <= 1'b0;
        found      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      n    <= desc_n;
      sum  <= desc_sum;
      sq   <= desc_sq;
      drop <= desc_drop;
      k2   <= K2_W'(thresh_k) * K2_W'(thresh_k);
    end
    if (state == S_NQ_W && mul_done) begin
      nq <= prod[MA-1:0];
    end
    if (state == S_RHS_W && mul_done) begin
      rhs <= prod;
      idx <= '0;
    end
    if (state == S_NV) begin
      nv <= SW'(n) * SW'(rd_data);
    end
    if (state == S_D2_W && mul_done) begin
      flag <= ({prod, 8'b0} > {8'b0, rhs});
    end
    if (state == S_EVAL && advance) begin
      if (flag) begin
        held_idx <= IDX_W'(idx);
      end
      idx <= idx + 1'b1;
    end
  end

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    desc_pop |=> busy)
    else $error("run taken without starting evaluation");

endmodule
